/* rtl/atm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_pkg: shared types and constants for the alpha-trimmed mean window
// Field widths, configuration register indexes, state encodings and the
// control word that steps the sorting cell chain.
// ----------------------------------------------------------------------------
package atm_pkg;

  // Field and register widths
  localparam int PIX_W       = 8;
  localparam int CODE_W      = 2;
  localparam int TRIM_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int SIDE_W      = 4;   // holds 3 + 2*code and any side up to 15
  localparam int D_W         = 3;   // trim amount never exceeds 5
  localparam int MAX_SIDE_DEF = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_REQUEST = 1'd1;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_FILL,
    ST_DRAIN,
    ST_HAND
  } ctl_state_t;

  // Divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic insert;  // place the broadcast pixel into sorted order
    logic drain;   // shift every value one cell toward cell 0
  } cell_ctrl_t;

endpackage

/* rtl/atm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_cell: one slot of the sorting chain
// Holds one pixel of the sorted window. On insert it keeps its value, takes
// the new pixel, or takes its left neighbor's value, so the chain stays in
// ascending order. On drain it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module atm_cell
  import atm_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]   count,
  input  logic [PIX_W-1:0]   pixel,
  input  logic [PIX_W-1:0]   left_val,
  input  logic               left_gt,
  input  logic [PIX_W-1:0]   right_val,
  output logic [PIX_W-1:0]   val,
  output logic               gt
);

  logic occupied;
  logic tail;

  // Slot status against the current fill count
  always_comb begin
    occupied = count > CNT_W'(IDX);
    tail     = count == CNT_W'(IDX);
    gt       = occupied && (val > pixel);
  end

  // Insert or shift
  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      val <= right_val;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt || tail) begin
        val <= pixel;
      end
    end
  end

endmodule

/* rtl/atm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_divider: restoring divider for the trimmed sum
// The quotient is known to fit in one pixel, so one quotient bit is
// produced per cycle. The result word is held until taken.
// ----------------------------------------------------------------------------
module atm_divider
  import atm_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PIX_W+CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0]       divisor,
  output logic                   start_ready,
  output logic [PIX_W-1:0]       quotient,
  output logic                   out_valid,
  input  logic                   out_ready
);

  localparam int STEP_W = $clog2(PIX_W);

  div_state_t         state;
  div_state_t         state_next;
  logic [CNT_W-1:0]   rem;
  logic [PIX_W-1:0]   qsh;
  logic [CNT_W-1:0]   dsr;
  logic [STEP_W-1:0]  step;
  logic [CNT_W:0]     trial;
  logic               ge;
  logic               last_step;

  // One restoring step
  always_comb begin
    trial     = {rem, qsh[PIX_W-1]};
    ge        = trial >= {1'b0, dsr};
    last_step = step == STEP_W'(PIX_W - 1);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_DONE;
      DIV_DONE: if (out_ready) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    start_ready = state == DIV_IDLE;
    out_valid   = state == DIV_DONE;
    quotient    = qsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: remainder, quotient shifter, step count
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem  <= dividend[PIX_W+CNT_W-1:PIX_W];
      qsh  <= dividend[PIX_W-1:0];
      dsr  <= divisor;
      step <= '0;
    end else if (state == DIV_RUN) begin
      rem  <= ge ? CNT_W'(trial - {1'b0, dsr}) : CNT_W'(trial);
      qsh  <= {qsh[PIX_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

/* rtl/alpha_trimmed_mean_window.sv */
`timescale 1ns / 1ps
// Sequence: pixels are taken while filling; after the window's closing pixel
// the chain drains to the accumulator, one value a cycle, then the sum is
// handed to the divider, whose result word is held until taken. The next window
// can fill while the divider works; the handoff waits until the divider is idle.
// Reset clears the fill count, sequencers and configuration; cell contents
// are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_window: trimmed mean over one square pixel window
// Pixels are insertion-sorted into a chain of cells as they arrive. When
// the window closes the chain drains through an accumulator that skips d
// values at each end, and the sum is divided by the count kept.
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_window
  import atm_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      window_mean
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PIX_W + CNT_W;

  // Configuration registers
  logic [CODE_W-1:0] window_code;
  logic [TRIM_W-1:0] trim_request;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_code  <= '0;
      trim_request <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WINDOW_CODE:  window_code  <= cfg_data[CODE_W-1:0];
        CFG_TRIM_REQUEST: trim_request <= cfg_data[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Window size and trim amount
  logic [SIDE_W-1:0]   side_raw;
  logic [SIDE_W-1:0]   side;
  logic [2*SIDE_W-1:0] n_full;
  logic [2*SIDE_W-1:0] half;
  logic [2*SIDE_W-1:0] lim;
  logic [2*SIDE_W-1:0] dmin;
  logic [D_W-1:0]      d;
  logic [CNT_W-1:0]    n_win;

  always_comb begin
    side_raw = SIDE_W'(3) + {1'b0, window_code, 1'b0};
    side     = (side_raw > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_raw;
    n_full   = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
    n_win    = CNT_W'(n_full);
    half     = (n_full - 1'b1) >> 1;
    lim      = (2*SIDE_W)'(window_code) + (2*SIDE_W)'(2);
    dmin     = (2*SIDE_W)'(trim_request);
    if (dmin > lim) dmin = lim;
    if (dmin > half) dmin = half;
    d        = D_W'(dmin);
  end

  // Sequencer registers
  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] drain_idx;
  logic [SUM_W-1:0] sum;

  logic             accept;
  logic [CNT_W-1:0] count_inc;
  logic             closing;
  logic             drain_last;
  logic [CNT_W-1:0] hi;
  logic             in_span;
  logic [CNT_W-1:0] kept;
  logic             div_start;
  logic             div_start_ready;
  cell_ctrl_t       cell_ctrl;

  logic [PIX_W-1:0] cell_val [DEPTH];
  logic             cell_gt  [DEPTH];

  always_comb begin
    accept     = in_valid && in_ready;
    count_inc  = count + 1'b1;
    closing    = count_inc >= n_win;
    drain_last = drain_idx == len - 1'b1;
    hi         = len - CNT_W'(d);
    in_span    = (drain_idx >= CNT_W'(d)) && (drain_idx < hi);
    kept       = len - (CNT_W'(d) << 1);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL:  if (accept && closing) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_last) state_next = ST_HAND;
      ST_HAND:  if (div_start_ready) state_next = ST_FILL;
      default:  state_next = ST_FILL;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready         = state == ST_FILL;
    div_start        = state == ST_HAND;
    cell_ctrl.insert = accept;
    cell_ctrl.drain  = state == ST_DRAIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= closing ? '0 : count_inc;
      end
    end
  end

  // Drain bookkeeping and trimmed accumulation
  always_ff @(posedge clk) begin
    if (accept && closing) begin
      len       <= count_inc;
      drain_idx <= '0;
      sum       <= '0;
    end else if (state == ST_DRAIN) begin
      drain_idx <= drain_idx + 1'b1;
      if (in_span) begin
        sum <= sum + SUM_W'(cell_val[0]);
      end
    end
  end

  // Sorting cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PIX_W-1:0] lv;
    logic             lg;
    logic [PIX_W-1:0] rv;

    if (i == 0) begin : g_head
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_body
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    atm_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .count     (count),
      .pixel     (pixel),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  // Divide the trimmed sum by the count kept
  atm_divider #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (sum),
    .divisor     (kept),
    .start_ready (div_start_ready),
    .quotient    (window_mean),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> count < CNT_W'(DEPTH))
    else $error("fill count reached store depth");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_HAND |-> kept != '0)
    else $error("trimmed window keeps no values");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && count >= CNT_W'(2)) |-> cell_val[0] <= cell_val[1])
    else $error("cell chain out of order");

  a_close_drains: assert property (@(posedge clk) disable iff (rst)
    (accept && closing) |=> (state == ST_DRAIN && count == '0))
    else $error("closing pixel did not start drain");

endmodule
